// ===== design/ptt_pkg.sv =====
// shared types and codes for the periodic tick timer table
// no dependencies; imported by every file of the block but ptt_ram

package ptt_pkg;

  // request modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // event kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  // error codes
  localparam logic ERR_OK    = 1'b0;
  localparam logic ERR_ARMED = 1'b1;

  // field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned IdW     = 4;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned CountW  = 32;

  // remainder unit: one dividend bit per cycle
  localparam int unsigned DivSteps = CountW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_DIV,
    S_HIT,
    S_NEXT,
    S_FLUSH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;      // request taken this cycle
    logic tick_start;  // bump count, restart scan
    logic scan_next;   // advance slot index
    logic div_load;    // start remainder of count by slot period
    logic div_step;    // one remainder iteration
    logic hit_take;    // park fired slot as pending
    logic hit_emit;    // send pending slot (not last), park fired slot
    logic flush_emit;  // send pending slot as last
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic armed_cur;   // current slot armed
    logic per_zero;    // current slot period is zero
    logic div_last;    // final remainder iteration
    logic rem_zero;    // remainder is zero
    logic pend_valid;  // a fired slot waits to be sent
    logic out_free;    // output register can load
    logic idx_last;    // current slot is the last one
  } status_t;

endpackage

// ===== design/ptt_req_if.sv =====
// request channel of the periodic tick timer table
// depends on ptt_pkg for field widths

interface ptt_req_if;
  import ptt_pkg::*;

  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [IdW-1:0]     timer_id;
  logic [PeriodW-1:0] period;

  modport source (output valid, mode, timer_id, period, input ready);
  modport sink (input valid, mode, timer_id, period, output ready);
endinterface

// ===== design/ptt_evt_if.sv =====
// event channel of the periodic tick timer table
// depends on ptt_pkg for field widths

interface ptt_evt_if;
  import ptt_pkg::*;

  logic           valid;
  logic           ready;
  logic           event_kind;
  logic [IdW-1:0] event_timer;
  logic           error_code;
  logic           last_event;

  modport source (output valid, event_kind, event_timer, error_code, last_event,
                  input ready);
  modport sink (input valid, event_kind, event_timer, error_code, last_event,
                output ready);
endinterface

// ===== design/ptt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module ptt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ptt_ctrl.sv =====
// controller of the periodic tick timer table: request accept and slot scan sequencing
// depends on ptt_pkg for state, command and status types

module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [ModeW-1:0] req_mode_i,
  output logic             req_ready_o,
  input  status_t          sts_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = sts_i.out_free;
        if (req_valid_i && sts_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (req_mode_i == MODE_TICK) begin
            cmd_o.tick_start = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = sts_i.armed_cur ? S_LOAD : S_NEXT;
      end
      S_LOAD: begin
        if (sts_i.per_zero) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_HIT;
        end
      end
      S_HIT: begin
        if (!sts_i.rem_zero) begin
          state_d = S_NEXT;
        end else if (!sts_i.pend_valid) begin
          cmd_o.hit_take = 1'b1;
          state_d        = S_NEXT;
        end else if (sts_i.out_free) begin
          cmd_o.hit_emit = 1'b1;
          state_d        = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts_i.idx_last) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_READ;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush_emit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // no fired slot is left parked once the scan is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !sts_i.pend_valid)
    else $error("pending fired slot left behind after scan");

  // the hit check is entered only after the last remainder iteration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HIT |-> $past(state_q) == S_DIV || $past(state_q) == S_HIT)
    else $error("hit check entered without remainder");
`endif

endmodule

// ===== design/ptt_dp.sv =====
// datapath of the periodic tick timer table: count, armed bits, period ram,
// bit-serial remainder unit, pending slot and output register
// depends on ptt_pkg and ptt_ram

module ptt_dp
  import ptt_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            sts_o,
  input  logic [ModeW-1:0]   req_mode_i,
  input  logic [IdW-1:0]     req_timer_id_i,
  input  logic [PeriodW-1:0] req_period_i,
  input  logic               evt_ready_i,
  output logic               evt_valid_o,
  output logic               evt_event_kind_o,
  output logic [IdW-1:0]     evt_event_timer_o,
  output logic               evt_error_code_o,
  output logic               evt_last_event_o
);

  localparam int unsigned IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  logic [CountW-1:0]      tick_q, tick_d;
  logic [TIMER_SLOTS-1:0] armed_q, armed_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [PeriodW-1:0]     per_rdata;
  logic [PeriodW-1:0]     per_q, per_d;
  logic [CountW-1:0]      dvd_q, dvd_d;
  logic [PeriodW-1:0]     rem_q, rem_d;
  logic [DivCntW-1:0]     cnt_q, cnt_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [IdW-1:0]         pend_id_q, pend_id_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_kind_q, out_kind_d;
  logic [IdW-1:0]         out_timer_q, out_timer_d;
  logic                   out_err_q, out_err_d;
  logic                   out_last_q, out_last_d;
  logic                   id_in_range;
  logic                   add_ok;
  logic                   out_free;
  logic [PeriodW:0]       rem_shift;
  logic [PeriodW:0]       rem_diff;

  assign id_in_range = 32'(req_timer_id_i) < 32'(TIMER_SLOTS);
  assign add_ok      = cmd_i.accept && req_mode_i == MODE_ADD && id_in_range &&
                       !armed_q[IdxW'(req_timer_id_i)];
  assign out_free    = !out_valid_q || evt_ready_i;

  // period store, read at the scan index
  ptt_ram #(
    .WIDTH(PeriodW),
    .DEPTH(TIMER_SLOTS)
  ) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (add_ok),
    .waddr_i (IdxW'(req_timer_id_i)),
    .wdata_i (req_period_i),
    .raddr_i (idx_q),
    .rdata_o (per_rdata)
  );

  // restoring remainder step: shift in next dividend bit, subtract if it fits
  assign rem_shift = {rem_q, dvd_q[CountW-1]};
  assign rem_diff  = rem_shift - {1'b0, per_q};

  // count, table and scan state
  always_comb begin
    tick_d  = tick_q;
    armed_d = armed_q;
    idx_d   = idx_q;
    if (cmd_i.tick_start) begin
      tick_d = tick_q + 1'b1;
      idx_d  = '0;
    end
    if (cmd_i.scan_next) begin
      idx_d = idx_q + 1'b1;
    end
    if (add_ok) begin
      armed_d[IdxW'(req_timer_id_i)] = 1'b1;
    end
    if (cmd_i.accept && req_mode_i == MODE_REMOVE && id_in_range) begin
      armed_d[IdxW'(req_timer_id_i)] = 1'b0;
    end
  end

  // remainder unit
  always_comb begin
    per_d = per_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.div_load) begin
      per_d = per_rdata;
      dvd_d = tick_q;
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[CountW-2:0], 1'b0};
      rem_d = rem_diff[PeriodW] ? rem_shift[PeriodW-1:0] : rem_diff[PeriodW-1:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  // pending fired slot and output register
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && !evt_ready_i;
    out_kind_d   = out_kind_q;
    out_timer_d  = out_timer_q;
    out_err_d    = out_err_q;
    out_last_d   = out_last_q;
    if (cmd_i.accept && (req_mode_i == MODE_ADD || req_mode_i == MODE_REMOVE)) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_STATUS;
      out_timer_d = req_timer_id_i;
      out_err_d   = (req_mode_i == MODE_ADD && !add_ok) ? ERR_ARMED : ERR_OK;
      out_last_d  = 1'b1;
    end
    if (cmd_i.hit_emit || cmd_i.flush_emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_FIRED;
      out_timer_d = pend_id_q;
      out_err_d   = ERR_OK;
      out_last_d  = cmd_i.flush_emit;
    end
    if (cmd_i.hit_take || cmd_i.hit_emit) begin
      pend_valid_d = 1'b1;
      pend_id_d    = IdW'(idx_q);
    end
    if (cmd_i.flush_emit) begin
      pend_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      armed_q      <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      tick_q       <= tick_d;
      armed_q      <= armed_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    per_q       <= per_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    pend_id_q   <= pend_id_d;
    out_kind_q  <= out_kind_d;
    out_timer_q <= out_timer_d;
    out_err_q   <= out_err_d;
    out_last_q  <= out_last_d;
  end

  // status back to the controller
  always_comb begin
    sts_o.armed_cur  = armed_q[idx_q];
    sts_o.per_zero   = per_rdata == '0;
    sts_o.div_last   = cnt_q == DivCntW'(DivSteps - 1);
    sts_o.rem_zero   = rem_q == '0;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
    sts_o.idx_last   = idx_q == IdxW'(TIMER_SLOTS - 1);
  end

  assign evt_valid_o       = out_valid_q;
  assign evt_event_kind_o  = out_kind_q;
  assign evt_event_timer_o = out_timer_q;
  assign evt_error_code_o  = out_err_q;
  assign evt_last_event_o  = out_last_q;

`ifndef SYNTHESIS
  // the output register is only loaded when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept || cmd_i.hit_emit || cmd_i.flush_emit) |-> out_free)
    else $error("output register overwritten");

  // the remainder unit never runs on a zero period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> per_q != '0)
    else $error("remainder by zero period");

  // a tick advances the count by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_start |=> tick_q == $past(tick_q) + 1'b1)
    else $error("tick count did not advance");
`endif

endmodule

// ===== design/periodic_tick_timer_table_unit.sv =====
// add/remove: status event in the output register the cycle after the request.
// tick: slots scanned in id order; an unarmed slot passes read and next, an
// armed one with a zero period also load, any other armed slot also the
// bit-serial remainder unit (one count bit per cycle) and the hit check; hit
// check and flush can wait on output stalls. reset (async, active low) zeroes
// the count and disarms every slot; the ram is not cleared, nor needs clearing.

module periodic_tick_timer_table_unit
  import ptt_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ptt_req_if.sink   req_i,
  ptt_evt_if.source evt_o
);

  cmd_t    cmd;
  status_t sts;

  // sequencing
  ptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_mode_i  (req_i.mode),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  ptt_dp #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_mode_i        (req_i.mode),
    .req_timer_id_i    (req_i.timer_id),
    .req_period_i      (req_i.period),
    .evt_ready_i       (evt_o.ready),
    .evt_valid_o       (evt_o.valid),
    .evt_event_kind_o  (evt_o.event_kind),
    .evt_event_timer_o (evt_o.event_timer),
    .evt_error_code_o  (evt_o.error_code),
    .evt_last_event_o  (evt_o.last_event)
  );

endmodule
